### src/pft_pkg.sv
// Shared types, widths and saturation helper for the pivot frame transform.
// No dependencies; every other file but src/pft_checker.sv imports this package.
package pft_pkg;
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int ACC_BITS = 2 * WORD_BITS - FRAC_BITS + 3;
	localparam int LANES = 4;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [ACC_BITS-1:0] acc_t;
	typedef logic signed [2*WORD_BITS-1:0] prod_t;

	localparam word_t ONE_Q = word_t'(1) << FRAC_BITS;
	localparam word_t MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t MIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		CMD_LOAD_COL = 3'd0,
		CMD_LOAD_CTR = 3'd1,
		CMD_XFORM_ROW = 3'd2,
		CMD_TO_GLOBAL = 3'd3,
		CMD_TO_LOCAL = 3'd4
	} cmd_t;

	typedef struct packed {
		word_t val;
		logic clip;
	} sat_t;

	typedef struct packed {
		word_t [LANES-1:0] r;
		logic sat;
	} res_t;

	function automatic sat_t sat_word(acc_t v);
		acc_t top;
		sat_t s;
		top = v >>> (WORD_BITS - 1);
		if (top == '0 || top == '1) begin
			s.val = v[WORD_BITS-1:0];
			s.clip = 1'b0;
		end else begin
			s.val = v[ACC_BITS-1] ? MIN_W : MAX_W;
			s.clip = 1'b1;
		end
		return s;
	endfunction
endpackage

### src/pft_lane.sv
// One multiply-accumulate lane: registered Q product, then a wide accumulator.
// Depends on pft_pkg.
module pft_lane (
	input  logic          clk,
	input  logic          clr,
	input  pft_pkg::word_t a,
	input  pft_pkg::word_t b,
	input  pft_pkg::acc_t  init,
	output pft_pkg::acc_t  sum
);
	import pft_pkg::*;

	prod_t prod_s1;
	acc_t acc_q;
	prod_t shifted;

	assign shifted = prod_s1 >>> FRAC_BITS;
	assign sum = acc_q + shifted[ACC_BITS-1:0];

	always_ff @(posedge clk) begin
		prod_s1 <= prod_t'(a) * prod_t'(b);
		acc_q <= clr ? init : sum;
	end
endmodule

### src/pft_merge.sv
// Merging stage: saturates the lane sums to words and combines the clip flags.
// Depends on pft_pkg.
module pft_merge (
	input  pft_pkg::acc_t sum [pft_pkg::LANES],
	output pft_pkg::res_t res
);
	import pft_pkg::*;

	always_comb begin
		sat_t s;
		res.sat = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			s = sat_word(sum[i]);
			res.r[i] = s.val;
			res.sat = res.sat | s.clip;
		end
	end
endmodule

### src/pivot_frame_transform_core.sv
// Pivot frame transform core: four MAC lanes, one dot-product step per cycle.
// Load commands leave the block idle; a point mapping passes the run and wait states.
// Row 3 of a transform occupies the lanes for five passes: basis columns, then center.
// Reset sets the basis to identity and the center to zero; pending rows are not reset.
// Depends on pft_pkg, pft_lane and pft_merge.
module pivot_frame_transform_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  cmd,
	input  logic [1:0]  index,
	input  logic signed [31:0] a0,
	input  logic signed [31:0] a1,
	input  logic signed [31:0] a2,
	input  logic signed [31:0] a3,
	output logic        res_valid,
	input  logic        res_ready,
	output logic signed [31:0] r0,
	output logic signed [31:0] r1,
	output logic signed [31:0] r2,
	output logic signed [31:0] r3,
	output logic        saturated
);
	import pft_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_t;

	state_t state_q;
	cmd_t op_q;
	logic [2:0] pass_q;
	logic [2:0] k_q;
	word_t basis_q [4][4];
	word_t center_q [4];
	word_t pending_q [3][4];
	word_t vec_q [4];
	logic dflag_q;
	res_t hold_q;
	res_t out_q;
	logic out_valid_q;

	word_t ain [4];
	sat_t dsat [4];
	logic dclip;
	word_t la [LANES];
	word_t lb [LANES];
	acc_t linit [LANES];
	acc_t lsum [LANES];
	res_t merged;
	logic [1:0] kk;
	logic accept;
	logic lane_clr;

	assign ain[0] = WORD_BITS'(a0);
	assign ain[1] = WORD_BITS'(a1);
	assign ain[2] = WORD_BITS'(a2);
	assign ain[3] = WORD_BITS'(a3);
	assign kk = k_q[1:0];
	assign cmd_ready = (state_q == ST_IDLE);
	assign accept = cmd_valid && cmd_ready;
	assign lane_clr = (k_q == 3'd0);

	always_comb begin
		dclip = 1'b0;
		for (int k = 0; k < 4; k++) begin
			dsat[k] = sat_word(acc_t'(ain[k]) - acc_t'(center_q[k]));
			dclip = dclip | dsat[k].clip;
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			la[i] = basis_q[kk][i];
			lb[i] = vec_q[kk];
			linit[i] = '0;
			case (op_q)
				CMD_TO_GLOBAL: begin
					linit[i] = acc_t'(center_q[i]);
				end
				CMD_TO_LOCAL: begin
					la[i] = basis_q[i][kk];
				end
				default: begin
					if (i < 3) la[i] = pending_q[i][kk];
					else la[i] = vec_q[kk];
					if (pass_q == 3'd4) lb[i] = center_q[kk];
					else lb[i] = basis_q[kk][pass_q[1:0]];
				end
			endcase
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		pft_lane u_lane (
			.clk  (clk),
			.clr  (lane_clr),
			.a    (la[g]),
			.b    (lb[g]),
			.init (linit[g]),
			.sum  (lsum[g])
		);
	end

	pft_merge u_merge (
		.sum (lsum),
		.res (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= CMD_TO_GLOBAL;
			pass_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < 4; r++) begin
				center_q[r] <= '0;
				for (int c = 0; c < 4; c++) basis_q[r][c] <= (r == c) ? ONE_Q : '0;
			end
		end else begin
			if (out_valid_q && res_ready && state_q != ST_WAIT) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						pass_q <= '0;
						for (int k = 0; k < 4; k++)
							vec_q[k] <= (cmd == CMD_TO_LOCAL) ? dsat[k].val : ain[k];
						case (cmd)
							CMD_LOAD_COL: begin
								for (int r = 0; r < 4; r++) basis_q[r][index] <= ain[r];
							end
							CMD_LOAD_CTR: begin
								for (int r = 0; r < 4; r++) center_q[r] <= ain[r];
							end
							CMD_XFORM_ROW: begin
								if (index == 2'd3) begin
									op_q <= CMD_XFORM_ROW;
									state_q <= ST_RUN;
								end else begin
									for (int k = 0; k < 4; k++) pending_q[index][k] <= ain[k];
								end
							end
							CMD_TO_GLOBAL: begin
								op_q <= CMD_TO_GLOBAL;
								dflag_q <= 1'b0;
								state_q <= ST_RUN;
							end
							CMD_TO_LOCAL: begin
								op_q <= CMD_TO_LOCAL;
								dflag_q <= dclip;
								state_q <= ST_RUN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					if (k_q == 3'd4) begin
						k_q <= '0;
						if (op_q == CMD_XFORM_ROW) begin
							if (pass_q == 3'd4) begin
								for (int r = 0; r < 4; r++) center_q[r] <= merged.r[r];
								state_q <= ST_IDLE;
							end else begin
								for (int r = 0; r < 4; r++)
									basis_q[r][pass_q[1:0]] <= merged.r[r];
								pass_q <= pass_q + 3'd1;
							end
						end else begin
							hold_q.r <= merged.r;
							hold_q.sat <= merged.sat | dflag_q;
							state_q <= ST_WAIT;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_WAIT: begin
					if (!out_valid_q || res_ready) begin
						out_q <= hold_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign r0 = 32'(out_q.r[0]);
	assign r1 = 32'(out_q.r[1]);
	assign r2 = 32'(out_q.r[2]);
	assign r3 = 32'(out_q.r[3]);
	assign saturated = out_q.sat;
endmodule

### src/pft_checker.sv
// Port-level checker for pivot_frame_transform_core, bound to the top level.
// Depends only on the top-level ports.
module pft_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [2:0]  cmd,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] r0,
	input logic        saturated
);
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("Result word shown during reset.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(r0) && $stable(saturated))
		else $error("Stalled result word changed or dropped.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd == 3'd3 || cmd == 3'd4) |=> !cmd_ready)
		else $error("Block took a word while mapping a point.");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd == 3'd3 || cmd == 3'd4) && !res_valid
		|=> !res_valid)
		else $error("Result word appeared too early.");
endmodule

bind pivot_frame_transform_core pft_port_props u_pft_port_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.r0        (r0),
	.saturated (saturated)
);

### tb/pft_checker.sv
// Checker for pivot_frame_transform_core: watches both channels, predicts results.
// Depends on pft_pkg for the command codes and Q constants; instantiated beside the block by tb_top.
module pft_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_ready,
	input  logic [2:0] cmd,
	input  logic [1:0] index,
	input  logic signed [31:0] a0,
	input  logic signed [31:0] a1,
	input  logic signed [31:0] a2,
	input  logic signed [31:0] a3,
	input  logic res_valid,
	input  logic res_ready,
	input  logic signed [31:0] r0,
	input  logic signed [31:0] r1,
	input  logic signed [31:0] r2,
	input  logic signed [31:0] r3,
	input  logic saturated,
	output int fail_count,
	output int pending,
	output int checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import pft_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef struct {
		logic signed [31:0] r[4];
		logic sat;
	} point_t;

	logic signed [31:0] basis[16];
	logic signed [31:0] center[4];
	logic signed [31:0] rows[12];
	point_t point_q[$];

	function automatic wide_t qmul(logic signed [31:0] x, logic signed [31:0] y);
		logic signed [63:0] xe;
		logic signed [63:0] ye;
		logic signed [63:0] p;
		xe = x;
		ye = y;
		p = xe * ye;
		return wide_t'(p >>> FRAC_BITS);
	endfunction

	function automatic logic signed [31:0] clip32(wide_t v, inout logic f);
		if (v > wide_t'(MAX_W)) begin
			f = 1'b1;
			return MAX_W;
		end
		if (v < wide_t'(MIN_W)) begin
			f = 1'b1;
			return MIN_W;
		end
		return v[31:0];
	endfunction

	task automatic apply_word(logic [2:0] c, logic [1:0] idx, logic signed [31:0] v[4]);
		logic signed [31:0] m[16];
		logic signed [31:0] nb[16];
		logic signed [31:0] nc[4];
		logic signed [31:0] d[4];
		point_t pt;
		wide_t acc;
		logic f;
		f = 1'b0;
		case (c)
			CMD_LOAD_COL: for (int i = 0; i < 4; i++) basis[i*4+idx] = v[i];
			CMD_LOAD_CTR: for (int i = 0; i < 4; i++) center[i] = v[i];
			CMD_XFORM_ROW: begin
				if (idx < 3) begin
					for (int i = 0; i < 4; i++) rows[idx*4+i] = v[i];
				end else begin
					for (int i = 0; i < 12; i++) m[i] = rows[i];
					for (int i = 0; i < 4; i++) m[12+i] = v[i];
					for (int i = 0; i < 4; i++) begin
						acc = 0;
						for (int k = 0; k < 4; k++) acc += qmul(m[i*4+k], center[k]);
						nc[i] = clip32(acc, f);
						for (int j = 0; j < 4; j++) begin
							acc = 0;
							for (int k = 0; k < 4; k++)
								acc += qmul(m[i*4+k], basis[k*4+j]);
							nb[i*4+j] = clip32(acc, f);
						end
					end
					center = nc;
					basis = nb;
				end
			end
			CMD_TO_GLOBAL: begin
				for (int i = 0; i < 4; i++) begin
					acc = wide_t'(center[i]);
					for (int k = 0; k < 4; k++) acc += qmul(basis[k*4+i], v[k]);
					pt.r[i] = clip32(acc, f);
				end
				pt.sat = f;
				point_q.push_back(pt);
			end
			CMD_TO_LOCAL: begin
				for (int k = 0; k < 4; k++)
					d[k] = clip32(wide_t'(v[k]) - wide_t'(center[k]), f);
				for (int i = 0; i < 4; i++) begin
					acc = 0;
					for (int k = 0; k < 4; k++) acc += qmul(basis[i*4+k], d[k]);
					pt.r[i] = clip32(acc, f);
				end
				pt.sat = f;
				point_q.push_back(pt);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] v[4];
		logic signed [31:0] got[4];
		point_t e;
		int errs;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) basis[i] = (i % 5 == 0) ? ONE_Q : '0;
			for (int i = 0; i < 4; i++) center[i] = '0;
			for (int i = 0; i < 12; i++) rows[i] = '0;
			point_q.delete();
			pending = 0;
			fail_count <= 0;
			checked <= 0;
		end else begin
			errs = 0;
			if (res_valid && res_ready) begin
				got = '{r0, r1, r2, r3};
				if (point_q.size() == 0) begin
					$error("result word with nothing expected");
					errs++;
				end else begin
					e = point_q.pop_front();
					checked <= checked + 1;
					for (int i = 0; i < 4; i++)
						if (got[i] !== e.r[i]) begin
							$error("r%0d expected %h actual %h", i, e.r[i], got[i]);
							errs++;
						end
					if (saturated !== e.sat) begin
						$error("saturated expected %b actual %b", e.sat, saturated);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			if (cmd_valid && cmd_ready) begin
				v = '{a0, a1, a2, a3};
				apply_word(cmd, index, v);
			end
			pending = point_q.size();
		end
	end
endmodule

### tb/tb_top.sv
// Top of the pivot_frame_transform_core testbench: clock, reset, stimulus, verdict.
// Depends on pft_pkg, the block's RTL and pft_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pft_pkg::*;

	localparam logic [2:0] CMD_SPARE = 3'd5;
	localparam int HOLD_CYCLES = 400;

	logic clk, arst_n;
	logic cmd_valid, cmd_ready, res_valid, res_ready, saturated;
	logic [2:0] cmd;
	logic [1:0] index;
	logic signed [31:0] a0, a1, a2, a3, r0, r1, r2, r3;
	int fail_count, pending, checked;
	int sent;
	bit hold_done;

	pivot_frame_transform_core dut (.*);
	pft_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [31:0] pick_word(bit tame);
		case ($urandom_range(0, 9))
			0: return tame ? ONE_Q : MIN_W;
			1: return tame ? -ONE_Q : MAX_W;
			2: return '0;
			3, 4, 5, 6: return $signed($urandom_range(0, 4 << FRAC_BITS)) - (2 << FRAC_BITS);
			default: return tame ? $signed($urandom_range(0, 1 << 17)) - (1 << 16)
				: $urandom;
		endcase
	endfunction

	task automatic send(logic [2:0] c, logic [1:0] idx, logic signed [31:0] v[4]);
		cmd_valid <= 1'b1;
		cmd <= c;
		index <= idx;
		a0 <= v[0];
		a1 <= v[1];
		a2 <= v[2];
		a3 <= v[3];
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sent++;
		if ($urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_rand(logic [2:0] c, logic [1:0] idx, bit tame);
		logic signed [31:0] v[4];
		for (int i = 0; i < 4; i++) v[i] = pick_word(tame);
		send(c, idx, v);
	endtask

	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sent >= 300) begin
				hold_done = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case ($urandom_range(0, 3))
				0: res_ready <= 1'b1;
				1: res_ready <= ~res_ready;
				default: res_ready <= ($urandom_range(0, 2) != 0);
			endcase
		end
	end

	initial begin
		logic signed [31:0] v[4];
		int n;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		index = '0;
		{a0, a1, a2, a3} = '0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		v = '{MAX_W, MIN_W, ONE_Q, -ONE_Q};
		send(CMD_TO_GLOBAL, 2'd3, v);
		send(CMD_TO_LOCAL, 2'd1, v);
		v = '{MIN_W, MIN_W, MIN_W, MIN_W};
		send(CMD_LOAD_CTR, 2'd2, '{MAX_W, MAX_W, MAX_W, MAX_W});
		send(CMD_TO_LOCAL, 2'd0, v);
		send(CMD_TO_GLOBAL, 2'd0, '{MAX_W, MAX_W, MAX_W, MAX_W});
		send(CMD_LOAD_COL, 2'd0, '{MAX_W, MIN_W, MAX_W, MIN_W});
		send(CMD_TO_GLOBAL, 2'd2, '{MAX_W, MAX_W, MIN_W, 32'sd1});
		for (int i = 0; i < 3; i++) send_rand(CMD_XFORM_ROW, 2'(i), 1'b1);
		send(CMD_XFORM_ROW, 2'd3, '{'0, '0, '0, ONE_Q});
		send(CMD_TO_LOCAL, 2'd3, '{32'sd0, 32'sd1, -32'sd1, ONE_Q});
		for (int c = CMD_SPARE; c < 8; c++) send_rand(3'(c), 2'($urandom), 1'b0);
		for (int i = 0; i < 4; i++) begin
			v = '{'0, '0, '0, '0};
			v[i] = ONE_Q;
			send(CMD_LOAD_COL, 2'(i), v);
		end
		send(CMD_LOAD_CTR, 2'd0, '{'0, '0, '0, '0});
		send_rand(CMD_TO_GLOBAL, 2'd1, 1'b0);

		while (sent < 750) begin
			n = $urandom_range(0, 9);
			if (n < 4) begin
				for (int i = 0; i < 4; i++) send_rand(CMD_XFORM_ROW, 2'(i), n != 0);
				repeat ($urandom_range(1, 4)) send_rand(3'($urandom_range(3, 4)), 2'($urandom), 1'b0);
			end else if (n < 6) begin
				for (int i = 0; i < 4; i++) send_rand(CMD_LOAD_COL, 2'(i), 1'b1);
				send_rand(CMD_LOAD_CTR, 2'($urandom), n == 4);
			end else if (n < 9) begin
				send_rand(3'($urandom_range(3, 4)), 2'($urandom), n == 6);
			end else begin
				send_rand(3'($urandom), 2'($urandom), 1'b0);
			end
		end
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("tb_top: %0d command words sent, %0d mapped points compared", sent, checked);
		$display("tb_top: long output hold-off %0s", hold_done ? "exercised" : "missed");
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end
endmodule
